[design/hevc_access_unit_splitter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the HEVC access unit splitter
// Concurrent check forms for the splitter RTL, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEVC_ACCESS_UNIT_SPLITTER_ASSERT_SVH
`define HEVC_ACCESS_UNIT_SPLITTER_ASSERT_SVH

// Same-cycle implication.
`define HEVCAUS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HEVCAUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hevcaus_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevcaus_pkg
// Types and constants shared by the access unit splitter files.
// ----------------------------------------------------------------------------
package hevcaus_pkg;

    localparam int DELAY_DEPTH = 4;
    localparam int MAX_RESULTS = 5;

    localparam logic [5:0] VCL_MAX   = 6'd31;
    localparam logic [5:0] IRAP_MIN  = 6'd16;
    localparam logic [5:0] IRAP_MAX  = 6'd23;
    localparam logic [7:0] TYPE_MASK = 8'h3F;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // Delay line plus unit tracking; q[0] is the oldest byte, the line is
    // right aligned so the newest held byte always sits at q[DELAY_DEPTH-1].
    typedef struct packed {
        logic [DELAY_DEPTH-1:0][7:0] q;
        logic [2:0]                  fill;
        logic                        seen_start;
        logic                        has_vcl;
        logic                        keyframe;
    } state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       unit_last;
        logic       is_keyframe;
        logic       drop_unit;
    } result_t;

endpackage

[design/hevcaus_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevcaus_in_if
// Input byte channel: valid/ready handshake with one stream byte per word.
// ----------------------------------------------------------------------------
interface hevcaus_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

[design/hevcaus_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevcaus_out_if
// Output channel: one access unit byte with its boundary flags per word.
// ----------------------------------------------------------------------------
interface hevcaus_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       unit_last;
    logic       is_keyframe;
    logic       drop_unit;

    modport source (output valid, output out_byte, output unit_last,
                    output is_keyframe, output drop_unit, input ready);
    modport sink   (input valid, input out_byte, input unit_last,
                    input is_keyframe, input drop_unit, output ready);
endinterface

[design/hevc_access_unit_splitter.sv]
`timescale 1ns / 1ps
`include "hevc_access_unit_splitter_assert.svh"
// ----------------------------------------------------------------------------
// hevc_access_unit_splitter
// Splits an HEVC Annex-B byte stream into access units with boundary flags.
// ----------------------------------------------------------------------------
// Usage:
//   stream carries one elementary stream byte per word, with stream_end set
//   on the final byte. units returns the bytes that belong to access units;
//   unit_last marks the final byte of each unit and carries is_keyframe and
//   drop_unit on that byte only.
// Throughput: one byte per clock. Each accepted byte yields at most one word,
//   except the final byte, whose flush of the four-byte delay line yields up
//   to four more; the input pauses only while the five-word result queue
//   lacks room for the held byte's words.
// Path: the words a byte causes reach units through the input register and
//   then the result queue; a byte itself leaves once four younger bytes have
//   arrived, or at the flush.
// Reset: the delay line and unit flags are cleared and the input register and
//   result queue are emptied; the first accepted byte starts a fresh stream.
//   After a flush the line fill and unit flags are cleared in the same way.
// Stall: a low units.ready holds the head word; once the held byte's words
//   no longer fit in the queue, stream.ready drops until words are taken.
// ----------------------------------------------------------------------------
module hevc_access_unit_splitter (
    input  logic                 clk,
    input  logic                 rst_n,
    hevcaus_in_if.sink           stream,
    hevcaus_out_if.source        units
);

    localparam int         NRES     = hevcaus_pkg::MAX_RESULTS;
    localparam logic [3:0] NRES_CNT = 4'(hevcaus_pkg::MAX_RESULTS);

    // Input register.
    logic       held_valid_reg;
    logic [7:0] held_byte_reg;
    logic       held_end_reg;

    // Parse state.
    hevcaus_pkg::state_t st_reg;
    hevcaus_pkg::state_t st_next;

    // Step results.
    hevcaus_pkg::result_t [NRES-1:0] res_step;
    logic [2:0]                      k_step;

    // Result queue, head at entry 0.
    hevcaus_pkg::result_t rq_reg  [NRES];
    hevcaus_pkg::result_t rq_next [NRES];
    logic [2:0]           cnt_reg;
    logic [2:0]           cnt_next;

    logic       fire;
    logic       pop;
    logic [2:0] base;
    logic [2:0] slot;

    hevcaus_step u_step (
        .cur        (st_reg),
        .data_byte  (held_byte_reg),
        .stream_end (held_end_reg),
        .nxt        (st_next),
        .res        (res_step),
        .count      (k_step)
    );

    // Process the held byte only when all of its words fit in the queue; the
    // check ignores this cycle's pop so units.ready never reaches stream.ready.
    assign fire = held_valid_reg && (({1'b0, cnt_reg} + {1'b0, k_step}) <= NRES_CNT);
    assign pop  = units.valid && units.ready;

    assign stream.ready = !held_valid_reg || fire;

    assign units.valid       = cnt_reg != 3'd0;
    assign units.out_byte    = rq_reg[0].out_byte;
    assign units.unit_last   = rq_reg[0].unit_last;
    assign units.is_keyframe = rq_reg[0].is_keyframe;
    assign units.drop_unit   = rq_reg[0].drop_unit;

    // Shift the queue down on pop, then append new words behind the survivors.
    always_comb
    begin
        base = cnt_reg - {2'b00, pop};
        for (int i = 0; i < NRES; i++)
        begin
            slot = 3'(i) - base;
            if (3'(i) < base)
                rq_next[i] = pop ? rq_reg[3'(i) + 3'(pop)] : rq_reg[i];
            else if (fire && (slot < k_step))
                rq_next[i] = res_step[slot];
            else
                rq_next[i] = rq_reg[i];
        end
        cnt_next = base + (fire ? k_step : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            cnt_reg        <= 3'd0;
            st_reg         <= '0;
        end
        else
        begin
            if (stream.valid && stream.ready)
                held_valid_reg <= 1'b1;
            else if (fire)
                held_valid_reg <= 1'b0;
            cnt_reg <= cnt_next;
            if (fire)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            held_byte_reg <= stream.data_byte;
            held_end_reg  <= stream.stream_end;
        end
        for (int i = 0; i < NRES; i++)
            rq_reg[i] <= rq_next[i];
    end

    `HEVCAUS_ASSERT_NOW(a_queue_bound, 1'b1, cnt_reg <= 3'(NRES),
        "result queue overfilled")
    `HEVCAUS_ASSERT_NEXT(a_flush_clears, fire && held_end_reg,
        (st_reg.fill == 3'd0) && !st_reg.seen_start && !st_reg.has_vcl,
        "flush left parse state behind")
    `HEVCAUS_ASSERT_NOW(a_drop_on_last, units.valid && units.drop_unit,
        units.unit_last, "drop flag off a last byte")
    `HEVCAUS_ASSERT_NOW(a_drop_not_key, units.valid && units.drop_unit,
        !units.is_keyframe, "dropped unit marked keyframe")

endmodule

[design/hevcaus_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevcaus_step
// Per-byte parse step: start code detect, unit close, delay line advance and
// end-of-stream flush list.
// ----------------------------------------------------------------------------
module hevcaus_step (
    input  hevcaus_pkg::state_t                                cur,
    input  logic [7:0]                                         data_byte,
    input  logic                                               stream_end,
    output hevcaus_pkg::state_t                                nxt,
    output hevcaus_pkg::result_t [hevcaus_pkg::MAX_RESULTS-1:0] res,
    output logic [2:0]                                         count
);

    localparam logic [2:0] FULL = 3'(hevcaus_pkg::DELAY_DEPTH);

    logic [7:0]          hdr_shift;
    logic [5:0]          hdr_type;
    logic                start;
    logic                vcl;
    logic                irap;
    logic                emit;
    logic                close;
    hevcaus_pkg::result_t step_res;
    hevcaus_pkg::state_t  adv;
    logic                code_tail;
    logic [1:0]          fs;
    logic [2:0]          fc;
    logic [1:0]          idx;
    hevcaus_pkg::result_t [hevcaus_pkg::DELAY_DEPTH-1:0] fl;

    always_comb
    begin
        hdr_shift = data_byte >> 1;
        hdr_type  = hdr_shift[5:0] & hevcaus_pkg::TYPE_MASK[5:0];
        start     = (cur.fill >= 3'd3) && (cur.q[1] == hevcaus_pkg::SC_ZERO)
                    && (cur.q[2] == hevcaus_pkg::SC_ZERO)
                    && (cur.q[3] == hevcaus_pkg::SC_ONE);
        vcl       = hdr_type <= hevcaus_pkg::VCL_MAX;
        irap      = hdr_type inside {[hevcaus_pkg::IRAP_MIN:hevcaus_pkg::IRAP_MAX]};

        // Oldest byte leaves once the line is full and a unit is open.
        emit  = (cur.fill == FULL) && cur.seen_start;
        close = start && vcl && cur.has_vcl;

        step_res.out_byte    = cur.q[0];
        step_res.unit_last   = close;
        step_res.is_keyframe = close && cur.keyframe;
        step_res.drop_unit   = 1'b0;

        // Advance the delay line and unit flags.
        adv.q[0]       = cur.q[1];
        adv.q[1]       = cur.q[2];
        adv.q[2]       = cur.q[3];
        adv.q[3]       = data_byte;
        adv.fill       = (cur.fill == FULL) ? FULL : cur.fill + 3'd1;
        adv.seen_start = cur.seen_start || start;
        adv.has_vcl    = close ? 1'b0 : cur.has_vcl;
        adv.keyframe   = close ? 1'b0 : cur.keyframe;
        if (start && vcl)
        begin
            adv.has_vcl  = 1'b1;
            adv.keyframe = adv.keyframe || irap;
        end

        // Flush list: everything held, or only a trailing start code when the
        // stream never opened a unit.
        code_tail = (adv.fill >= 3'd3) && (adv.q[1] == hevcaus_pkg::SC_ZERO)
                    && (adv.q[2] == hevcaus_pkg::SC_ZERO)
                    && (adv.q[3] == hevcaus_pkg::SC_ONE);
        if (adv.seen_start)
        begin
            fs = 2'(FULL - adv.fill);
            fc = adv.fill;
        end
        else if (code_tail)
        begin
            fs = 2'd1;
            fc = 3'd3;
        end
        else
        begin
            fs = 2'd0;
            fc = 3'd0;
        end

        for (int i = 0; i < hevcaus_pkg::DELAY_DEPTH; i++)
        begin
            idx                  = fs + 2'(i);
            fl[i].out_byte       = adv.q[idx];
            fl[i].unit_last      = (fc != 3'd0) && (3'(i) == fc - 3'd1);
            fl[i].is_keyframe    = fl[i].unit_last && adv.keyframe;
            fl[i].drop_unit      = fl[i].unit_last && !adv.has_vcl;
        end

        // Step word first when a byte leaves the line, then the flush list.
        if (emit)
            res = {fl, step_res};
        else
            res = {hevcaus_pkg::result_t'('0), fl};

        count = {2'b00, emit} + (stream_end ? fc : 3'd0);

        nxt = adv;
        if (stream_end)
        begin
            nxt.fill       = 3'd0;
            nxt.seen_start = 1'b0;
            nxt.has_vcl    = 1'b0;
            nxt.keyframe   = 1'b0;
        end
    end

endmodule
